### rtl/ue_slot_allocator_with_id_lookup_macros.svh
// Assertion macros for the slot allocator with identifier lookup.
// Used by ue_slot_allocator_with_id_lookup.sv; no other dependencies.
`ifndef UE_SLOT_ALLOCATOR_WITH_ID_LOOKUP_MACROS_SVH
`define UE_SLOT_ALLOCATOR_WITH_ID_LOOKUP_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define UESA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequence that holds in the same cycle as the antecedent.
`define UESA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that holds in the cycle after the antecedent.
`define UESA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/uesa_pkg.sv
// Shared types, constants and helper functions of the slot allocator.
// No dependencies; used by uesa_cell and ue_slot_allocator_with_id_lookup.
`timescale 1ns / 1ps

package uesa_pkg;

  localparam int NUM_SLOTS    = 64;
  localparam int RESERVED_ID  = 0;

  localparam int ID_W     = 16;
  localparam int REQ_W    = 2;
  localparam int SIDX_W   = 6;
  localparam int STATUS_W = 3;
  localparam int RSLOT_W  = 6;
  localparam int OCC_W    = 7;

  localparam int GRP        = 8;
  localparam int GRP_W      = 3;
  localparam int NUM_GROUPS = (NUM_SLOTS + GRP - 1) / GRP;
  localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int IDX_W      = GIDX_W + GRP_W;
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD         = 2'd0,
    REQ_REMOVE      = 2'd1,
    REQ_LOOKUP_ID   = 2'd2,
    REQ_LOOKUP_SLOT = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   radio_id;
    logic [SIDX_W-1:0] slot_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RSLOT_W-1:0]  result_slot;
    logic [ID_W-1:0]     result_id;
    logic [OCC_W-1:0]    occupied_count;
  } rsp_t;

  // Search token handed from group to group.
  typedef struct packed {
    logic             active;
    logic [REQ_W-1:0] req_type;
    logic [ID_W-1:0]  radio_id;
    logic [IDX_W-1:0] slot;
    logic             in_range;
    logic             hit;
    logic [IDX_W-1:0] hit_slot;
    logic             free_found;
    logic [IDX_W-1:0] free_slot;
    logic [ID_W-1:0]  rd_id;
  } tok_t;

  // Slot claim broadcast to all groups.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] slot;
    logic [ID_W-1:0]  radio_id;
  } wr_t;

  function automatic logic [GRP_W-1:0] lowest_set(input logic [GRP-1:0] v);
    logic [GRP_W-1:0] res;
    res = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (v[i]) begin
        res = GRP_W'(i);
      end
    end
    return res;
  endfunction

  function automatic logic [GRP-1:0] present_mask(input int g);
    logic [GRP-1:0] m;
    m = '0;
    for (int i = 0; i < GRP; i++) begin
      m[i] = ((g * GRP + i) < NUM_SLOTS);
    end
    return m;
  endfunction

endpackage

### rtl/uesa_cell.sv
// One group of eight user slots: valid marks, identifiers and the token stage.
// Depends on uesa_pkg.
`timescale 1ns / 1ps

module uesa_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [uesa_pkg::GIDX_W-1:0]    group_id,
  input  logic [uesa_pkg::GRP-1:0]       present,
  input  uesa_pkg::tok_t                 tok_in,
  input  uesa_pkg::wr_t                  wr,
  output uesa_pkg::tok_t                 tok_out
);

  logic [uesa_pkg::GRP-1:0]  valid;
  logic [uesa_pkg::ID_W-1:0] ids [uesa_pkg::GRP];

  uesa_pkg::tok_t               tok_next;
  logic [uesa_pkg::GRP-1:0]     match;
  logic [uesa_pkg::GRP-1:0]     free;
  logic [uesa_pkg::GRP_W-1:0]   sel;
  logic                         mine;
  logic                         search;
  logic                         clr;
  logic                         wr_mine;
  logic [uesa_pkg::GRP_W-1:0]   wr_sel;

  assign sel     = tok_in.slot[uesa_pkg::GRP_W-1:0];
  assign mine    = tok_in.in_range &&
                   (tok_in.slot[uesa_pkg::IDX_W-1:uesa_pkg::GRP_W] == group_id);
  assign search  = (tok_in.req_type == uesa_pkg::REQ_ADD) ||
                   (tok_in.req_type == uesa_pkg::REQ_LOOKUP_ID);
  assign wr_sel  = wr.slot[uesa_pkg::GRP_W-1:0];
  assign wr_mine = wr.en && (wr.slot[uesa_pkg::IDX_W-1:uesa_pkg::GRP_W] == group_id);

  always_comb begin
    tok_next = tok_in;
    clr      = 1'b0;
    for (int i = 0; i < uesa_pkg::GRP; i++) begin
      match[i] = present[i] && valid[i] && (ids[i] == tok_in.radio_id);
      free[i]  = present[i] && !valid[i];
    end
    if (tok_in.active) begin
      if (search) begin
        if (!tok_in.hit && (|match)) begin
          tok_next.hit      = 1'b1;
          tok_next.hit_slot = {group_id, uesa_pkg::lowest_set(match)};
        end
        if (!tok_in.free_found && (|free)) begin
          tok_next.free_found = 1'b1;
          tok_next.free_slot  = {group_id, uesa_pkg::lowest_set(free)};
        end
      end else if (mine) begin
        tok_next.hit   = valid[sel];
        tok_next.rd_id = ids[sel];
        clr            = (tok_in.req_type == uesa_pkg::REQ_REMOVE) && valid[sel];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (clr) begin
        valid[sel] <= 1'b0;
      end
      if (wr_mine) begin
        valid[wr_sel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_mine) begin
      ids[wr_sel] <= wr.radio_id;
    end
  end

endmodule

### rtl/ue_slot_allocator_with_id_lookup.sv
// Top level of the user slot allocator with identifier lookup.
// Depends on uesa_pkg, uesa_cell and ue_slot_allocator_with_id_lookup_macros.svh.
//
// Usage:
//   req (valid/ready) carries one request: add identifier, remove slot,
//   lookup by identifier or lookup by slot. rsp (valid/ready) returns one
//   result per request with status, slot, identifier and occupied count.
//   A search token walks a row of NUM_GROUPS cells, eight slots per cell,
//   one cell per cycle. The first cell holding a match or a free slot fills
//   the token; the slot requests read or clear their slot on the way.
//   A new request is taken only once the block is back in idle, after the
//   walk of the token along the row, its capture and the result load.
//   A claimed slot is written in the cycle after its result is loaded.
//   One request is in flight at a time; the result register lets the next
//   request start while a result waits. If rsp_ready stays low, the next
//   request finishes its walk and holds until the result register frees.
//   Reset clears all slots and the occupied count; identifiers of free
//   slots are never read, so they need no clearing.
`timescale 1ns / 1ps
`include "ue_slot_allocator_with_id_lookup_macros.svh"

module ue_slot_allocator_with_id_lookup (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  uesa_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output uesa_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HOLD
  } state_t;

  state_t                       state;
  uesa_pkg::tok_t               start_tok;
  uesa_pkg::tok_t               start_next;
  uesa_pkg::tok_t               fin;
  uesa_pkg::wr_t                wr;
  logic [uesa_pkg::CNT_W-1:0]   used_count;
  uesa_pkg::tok_t               chain [uesa_pkg::NUM_GROUPS+1];

  logic [uesa_pkg::STATUS_W-1:0] res_status;
  logic [uesa_pkg::RSLOT_W-1:0]  res_slot;
  logic [uesa_pkg::ID_W-1:0]     res_id;
  logic [uesa_pkg::CNT_W-1:0]    count_next;
  logic                          claim;
  logic                          accept;
  logic                          load;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign load      = (state == S_HOLD) && (!rsp_valid || rsp_ready);

  always_comb begin
    start_next            = '0;
    start_next.active     = accept;
    start_next.req_type   = req.req_type;
    start_next.radio_id   = req.radio_id;
    start_next.slot       = uesa_pkg::IDX_W'(req.slot_index);
    start_next.in_range   = (32'(req.slot_index) < uesa_pkg::NUM_SLOTS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_tok <= '0;
    end else begin
      start_tok <= start_next;
    end
  end

  assign chain[0] = start_tok;

  for (genvar g = 0; g < uesa_pkg::NUM_GROUPS; g++) begin : g_cell
    uesa_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .group_id (uesa_pkg::GIDX_W'(g)),
      .present  (uesa_pkg::present_mask(g)),
      .tok_in   (chain[g]),
      .wr       (wr),
      .tok_out  (chain[g+1])
    );
  end

  always_comb begin
    res_status = uesa_pkg::ST_OK;
    res_slot   = '0;
    res_id     = '0;
    count_next = used_count;
    claim      = 1'b0;
    case (fin.req_type)
      uesa_pkg::REQ_ADD: begin
        if (32'(fin.radio_id) == uesa_pkg::RESERVED_ID) begin
          res_status = uesa_pkg::ST_INVALID;
        end else if (fin.hit) begin
          res_status = uesa_pkg::ST_DUPLICATE;
        end else if (!fin.free_found) begin
          res_status = uesa_pkg::ST_FULL;
        end else begin
          res_slot   = uesa_pkg::RSLOT_W'(fin.free_slot);
          count_next = used_count + uesa_pkg::CNT_W'(1);
          claim      = 1'b1;
        end
      end
      uesa_pkg::REQ_REMOVE: begin
        if (fin.hit) begin
          count_next = used_count - uesa_pkg::CNT_W'(1);
        end else begin
          res_status = uesa_pkg::ST_NOT_FOUND;
        end
      end
      uesa_pkg::REQ_LOOKUP_ID: begin
        if (fin.hit) begin
          res_slot = uesa_pkg::RSLOT_W'(fin.hit_slot);
        end else begin
          res_status = uesa_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (fin.hit) begin
          res_id = fin.rd_id;
        end else begin
          res_status = uesa_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rsp_valid  <= 1'b0;
      wr.en      <= 1'b0;
      used_count <= '0;
    end else begin
      wr.en <= load && claim;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (chain[uesa_pkg::NUM_GROUPS].active) begin
            fin   <= chain[uesa_pkg::NUM_GROUPS];
            state <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load) begin
            rsp.status             <= res_status;
            rsp.result_slot        <= res_slot;
            rsp.result_id          <= res_id;
            rsp.occupied_count     <= uesa_pkg::OCC_W'(count_next);
            used_count             <= count_next;
            wr.slot                <= fin.free_slot;
            wr.radio_id            <= fin.radio_id;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `UESA_ASSERT_ALWAYS(a_count_bound, clk, rst, 32'(used_count) <= uesa_pkg::NUM_SLOTS, "occupied count beyond slot total")
  `UESA_ASSERT_IMP(a_token_in_scan, clk, rst, chain[uesa_pkg::NUM_GROUPS].active, state == S_SCAN, "token left the row outside scan")
  `UESA_ASSERT_IMP(a_claim_ok, clk, rst, wr.en, rsp_valid && (rsp.status == uesa_pkg::ST_OK), "slot claimed without a successful add result")
  `UESA_ASSERT_NEXT(a_count_held, clk, rst, state == S_SCAN, used_count == $past(used_count), "occupied count changed during scan")

endmodule

### tb/ue_slot_table_checker.sv
// Transaction checker for the user slot allocator: predicts every result from
// the accepted requests and compares it with the result the block returns.
// Depends on uesa_pkg for the request, result and code types.
`timescale 1ns / 1ps

module ue_slot_table_checker
  import uesa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  input  logic  req_ready,
  input  req_t  req,
  input  logic  rsp_valid,
  input  logic  rsp_ready,
  input  rsp_t  rsp,
  output int    fail_count,
  output int    pending,
  output int    checked_count,
  output int    full_count
);

  bit              slot_taken [NUM_SLOTS];
  logic [ID_W-1:0] slot_owner [NUM_SLOTS];
  int              taken_total;
  rsp_t            expected_rsps[$];

  function automatic rsp_t apply_table_request(input req_t r);
    rsp_t o;
    int   hit;
    int   free_slot;
    int   s;
    o = '0;
    o.status = ST_OK;
    hit = -1;
    free_slot = -1;
    s = int'(r.slot_index);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hit < 0 && slot_taken[i] && slot_owner[i] == r.radio_id) hit = i;
      if (free_slot < 0 && !slot_taken[i]) free_slot = i;
    end
    case (req_kind_t'(r.req_type))
      REQ_ADD: begin
        if (r.radio_id == ID_W'(RESERVED_ID)) begin
          o.status = ST_INVALID;
        end else if (hit >= 0) begin
          o.status = ST_DUPLICATE;
        end else if (free_slot < 0) begin
          o.status = ST_FULL;
        end else begin
          slot_taken[free_slot] = 1'b1;
          slot_owner[free_slot] = r.radio_id;
          taken_total++;
          o.result_slot = RSLOT_W'(free_slot);
        end
      end
      REQ_REMOVE: begin
        if (s < NUM_SLOTS && slot_taken[s]) begin
          slot_taken[s] = 1'b0;
          taken_total--;
        end else begin
          o.status = ST_NOT_FOUND;
        end
      end
      REQ_LOOKUP_ID: begin
        if (hit >= 0) o.result_slot = RSLOT_W'(hit);
        else o.status = ST_NOT_FOUND;
      end
      default: begin
        if (s < NUM_SLOTS && slot_taken[s]) o.result_id = slot_owner[s];
        else o.status = ST_NOT_FOUND;
      end
    endcase
    o.occupied_count = OCC_W'(taken_total);
    return o;
  endfunction

  initial begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_taken[i] = 1'b0;
      slot_owner[i] = '0;
    end
    taken_total = 0;
    fail_count = 0;
    pending = 0;
    checked_count = 0;
    full_count = 0;
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    bit   bad;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transaction: status %0d", rsp.status);
          fail_count++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          bad = 1'b0;
          if (rsp.status !== exp_rsp.status) begin
            $error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
            bad = 1'b1;
          end
          if (rsp.result_slot !== exp_rsp.result_slot) begin
            $error("result_slot: expected %0d, actual %0d",
                   exp_rsp.result_slot, rsp.result_slot);
            bad = 1'b1;
          end
          if (rsp.result_id !== exp_rsp.result_id) begin
            $error("result_id: expected 0x%04h, actual 0x%04h",
                   exp_rsp.result_id, rsp.result_id);
            bad = 1'b1;
          end
          if (rsp.occupied_count !== exp_rsp.occupied_count) begin
            $error("occupied_count: expected %0d, actual %0d",
                   exp_rsp.occupied_count, rsp.occupied_count);
            bad = 1'b1;
          end
          if (bad) fail_count++;
          if (exp_rsp.status == ST_FULL) full_count++;
          checked_count++;
        end
      end
      if (req_valid && req_ready) begin
        expected_rsps.push_back(apply_table_request(req));
      end
      pending = expected_rsps.size();
    end
  end

endmodule

### tb/ue_slot_allocator_with_id_lookup_tb.sv
// Testbench top for the user slot allocator: drives directed and random
// request transactions in bursts, stalls the result side, and gives the verdict.
// Depends on uesa_pkg, the block under test and ue_slot_table_checker.
`timescale 1ns / 1ps

module ue_slot_allocator_with_id_lookup_tb;
  import uesa_pkg::*;

  localparam int RANDOM_ITEMS = 1850;
  localparam int IDLE_LIMIT   = 2000;
  localparam int POOL_SIZE    = 96;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  int fail_count;
  int pending;
  int checked_count;
  int full_count;

  logic [ID_W-1:0] id_pool [POOL_SIZE];
  int kind_sent [4];
  int burst_left;
  int idle_cycles;
  int stall_left;
  int run_left;
  bit flicker;

  ue_slot_allocator_with_id_lookup i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  ue_slot_table_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .rsp           (rsp),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .full_count    (full_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic req_t make_req(input req_kind_t k, input logic [ID_W-1:0] id,
                                    input logic [SIDX_W-1:0] s);
    req_t r;
    r.req_type = k;
    r.radio_id = id;
    r.slot_index = s;
    return r;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    int c;
    c = $urandom_range(0, 19);
    if (c == 0) return ID_W'(RESERVED_ID);
    if (c < 9) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return ID_W'($urandom_range(1, 65535));
  endfunction

  function automatic logic [SIDX_W-1:0] pick_slot();
    if ($urandom_range(0, 1) == 0) return SIDX_W'($urandom_range(0, 63));
    return SIDX_W'($urandom_range(0, 15));
  endfunction

  // Episode 0 fills the table, 1 drains it, 2 mixes all kinds evenly.
  function automatic req_t random_req(input int episode);
    int c;
    req_kind_t k;
    c = $urandom_range(0, 99);
    case (episode)
      0: k = (c < 85) ? REQ_ADD : (c < 90) ? REQ_LOOKUP_ID :
             (c < 95) ? REQ_LOOKUP_SLOT : REQ_REMOVE;
      1: k = (c < 55) ? REQ_REMOVE : (c < 70) ? REQ_LOOKUP_ID :
             (c < 85) ? REQ_LOOKUP_SLOT : REQ_ADD;
      default: k = req_kind_t'(REQ_W'(c % 4));
    endcase
    if (k == REQ_LOOKUP_ID && $urandom_range(0, 9) < 6) begin
      return make_req(k, id_pool[$urandom_range(0, POOL_SIZE - 1)], pick_slot());
    end
    return make_req(k, pick_id(), pick_slot());
  endfunction

  task automatic send_req(input req_t r);
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    kind_sent[r.req_type]++;
    burst_left--;
    if (burst_left <= 0) begin
      req_valid <= 1'b0;
      req <= make_req(req_kind_t'(REQ_W'($urandom_range(0, 3))), ID_W'($urandom),
                      SIDX_W'($urandom));
      repeat ($urandom_range(1, 16)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      rsp_ready <= 1'b0;
      stall_left--;
    end else if (run_left > 0) begin
      rsp_ready <= flicker ? ($urandom_range(0, 3) != 0) : 1'b1;
      run_left--;
    end else begin
      stall_left = $urandom_range(0, 24);
      run_left = $urandom_range(1, 60);
      flicker = $urandom_range(0, 2) == 0;
      rsp_ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int done;
    int episode;
    int ep_len;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_ready = 1'b0;
    idle_cycles = 0;
    stall_left = 0;
    run_left = 0;
    flicker = 1'b0;
    burst_left = $urandom_range(1, 40);
    for (int i = 0; i < 4; i++) kind_sent[i] = 0;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom_range(1, 65535));
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_req(make_req(REQ_ADD, 16'h0000, 6'd0));
    send_req(make_req(REQ_ADD, 16'hFFFF, 6'd63));
    send_req(make_req(REQ_ADD, 16'h0001, 6'd0));
    send_req(make_req(REQ_ADD, 16'hFFFF, 6'd0));
    send_req(make_req(REQ_LOOKUP_ID, 16'hFFFF, 6'd0));
    send_req(make_req(REQ_LOOKUP_ID, 16'h0001, 6'd63));
    send_req(make_req(REQ_LOOKUP_ID, 16'h0000, 6'd0));
    send_req(make_req(REQ_LOOKUP_ID, 16'h8000, 6'd0));
    send_req(make_req(REQ_LOOKUP_SLOT, 16'h0000, 6'd0));
    send_req(make_req(REQ_LOOKUP_SLOT, 16'hFFFF, 6'd63));
    send_req(make_req(REQ_REMOVE, 16'h0000, 6'd63));
    send_req(make_req(REQ_REMOVE, 16'hFFFF, 6'd0));
    send_req(make_req(REQ_REMOVE, 16'h0000, 6'd0));
    send_req(make_req(REQ_LOOKUP_SLOT, 16'h0000, 6'd0));
    send_req(make_req(REQ_LOOKUP_ID, 16'hFFFF, 6'd0));
    send_req(make_req(REQ_ADD, 16'hAAAA, 6'd0));
    send_req(make_req(REQ_ADD, 16'h5555, 6'd0));
    send_req(make_req(REQ_LOOKUP_SLOT, 16'h0000, 6'd2));
    send_req(make_req(REQ_REMOVE, 16'h0000, 6'd1));
    send_req(make_req(REQ_REMOVE, 16'h0000, 6'd2));
    send_req(make_req(REQ_REMOVE, 16'h0000, 6'd0));

    done = 0;
    episode = 0;
    ep_len = 120;
    while (done < RANDOM_ITEMS) begin
      for (int j = 0; j < ep_len && done < RANDOM_ITEMS; j++) begin
        send_req(random_req(episode));
        done++;
      end
      episode = $urandom_range(0, 2);
      ep_len = $urandom_range(30, 150);
    end

    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);

    $display("Sent %0d add, %0d remove, %0d lookup-by-id, %0d lookup-by-slot requests.",
             kind_sent[REQ_ADD], kind_sent[REQ_REMOVE], kind_sent[REQ_LOOKUP_ID],
             kind_sent[REQ_LOOKUP_SLOT]);
    $display("Checked %0d results; the table reported full %0d times.",
             checked_count, full_count);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/uesa_pkg.sv
rtl/uesa_cell.sv
rtl/ue_slot_allocator_with_id_lookup.sv
tb/ue_slot_table_checker.sv
tb/ue_slot_allocator_with_id_lookup_tb.sv
